[sv/imu_pfp_pkg.sv]
package imu_pfp_pkg;

	// framing constants
	localparam logic [7:0] HEADER_BYTE      = 8'h55;
	localparam int         PACKET_BYTES     = 11;
	localparam int         PACKETS_PER_GROUP_DEF = 4;
	localparam int         POS_W            = 4;
	localparam int         PKT_W            = 2;
	localparam int         PAYLOAD_BYTES    = 6;
	localparam int         PAYLOAD_IDX_W    = 3;

	// register file
	localparam int         CFG_IDX_W        = 2;
	localparam int         CFG_DATA_W       = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_CODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_CODE = 2'd2;
	localparam logic [7:0] ACCEL_CODE_RST   = 8'h51;
	localparam logic [7:0] RATE_CODE_RST    = 8'h52;
	localparam logic [7:0] ANGLE_CODE_RST   = 8'h53;

	// packet kinds
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_ACCEL   = 2'd0;
	localparam kind_t KIND_RATE    = 2'd1;
	localparam kind_t KIND_ANGLE   = 2'd2;
	localparam kind_t KIND_UNKNOWN = 2'd3;

endpackage

[sv/imu_pfp_if.sv]
// byte channel into the parser
interface imu_pfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// decoded packet channel out of the parser
interface imu_pfp_pkt_if;
	import imu_pfp_pkg::*;
	logic               valid;
	logic               ready;
	kind_t              packet_kind;
	logic               sum_ok;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] axis_z;
	logic               group_end;

	modport source (output valid, output packet_kind, output sum_ok, output axis_x,
		output axis_y, output axis_z, output group_end, input ready);
	modport sink   (input valid, input packet_kind, input sum_ok, input axis_x,
		input axis_y, input axis_z, input group_end, output ready);
endinterface

[sv/imu_packet_frame_parser.sv]
// A checksum byte passes from the input register into the result register.
// Throughput: one byte per cycle; a stalled result holds the input register,
// which takes a new byte as soon as that register moves into the result slot.
// Reset (arst_n low, asynchronous): hunting for the header, counters and sum
// cleared, type codes at 0x51/0x52/0x53, both channels empty.
module imu_packet_frame_parser #(
	parameter int PACKETS_PER_GROUP = imu_pfp_pkg::PACKETS_PER_GROUP_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [imu_pfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [imu_pfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	imu_pfp_byte_if.sink                        rx,
	imu_pfp_pkt_if.source                       res
);
	import imu_pfp_pkg::*;

	localparam logic [PKT_W-1:0] LAST_PKT = PKT_W'(PACKETS_PER_GROUP - 1);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

	// configuration
	logic [7:0] accel_code_q, rate_code_q, angle_code_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// framing state
	logic             hunting_q;
	logic [POS_W-1:0] byte_pos_q;
	logic [PKT_W-1:0] pkt_pos_q;
	logic [7:0]       sum_q;
	logic [7:0]       type_q;
	logic [7:0]       payload_q [PAYLOAD_BYTES];

	// result register
	logic               out_valid_q;
	kind_t              kind_q;
	logic               sum_ok_q;
	logic signed [15:0] axis_x_q, axis_y_q, axis_z_q;
	logic               group_end_q;

	logic  out_free, proc, emit, last_byte, last_pkt;
	kind_t kind;
	logic [PAYLOAD_IDX_W-1:0] pay_idx;

	assign out_free  = !out_valid_q || res.ready;
	assign proc      = valid_s1 && out_free;
	assign rx.ready  = !valid_s1 || out_free;
	assign last_byte = (byte_pos_q == LAST_POS);
	assign last_pkt  = (pkt_pos_q == LAST_PKT);
	assign emit      = proc && !hunting_q && last_byte;
	assign pay_idx   = PAYLOAD_IDX_W'(byte_pos_q - POS_W'(2));

	// type classification, first matching code wins
	always_comb begin
		priority if (type_q == accel_code_q) kind = KIND_ACCEL;
		else if (type_q == rate_code_q)      kind = KIND_RATE;
		else if (type_q == angle_code_q)     kind = KIND_ANGLE;
		else                                 kind = KIND_UNKNOWN;
	end

	// configuration writes; unused index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_code_q <= ACCEL_CODE_RST;
			rate_code_q  <= RATE_CODE_RST;
			angle_code_q <= ANGLE_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACCEL_CODE: accel_code_q <= cfg_data;
				CFG_RATE_CODE:  rate_code_q  <= cfg_data;
				CFG_ANGLE_CODE: angle_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// framing counters and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q  <= 1'b1;
			byte_pos_q <= '0;
			pkt_pos_q  <= '0;
			sum_q      <= '0;
		end else if (proc) begin
			if (hunting_q) begin
				if (byte_s1 == HEADER_BYTE) begin
					hunting_q  <= 1'b0;
					pkt_pos_q  <= '0;
					byte_pos_q <= POS_W'(1);
					sum_q      <= byte_s1;
				end
			end else if (!last_byte) begin
				sum_q      <= sum_q + byte_s1;
				byte_pos_q <= byte_pos_q + POS_W'(1);
			end else begin
				sum_q      <= '0;
				byte_pos_q <= '0;
				if (last_pkt) begin
					hunting_q <= 1'b1;
					pkt_pos_q <= '0;
				end else begin
					pkt_pos_q <= pkt_pos_q + PKT_W'(1);
				end
			end
		end
	end

	// type and payload capture
	always_ff @(posedge clk) begin
		if (proc && !hunting_q) begin
			if (byte_pos_q == POS_W'(1)) begin
				type_q <= byte_s1;
			end else if (byte_pos_q >= POS_W'(2) && byte_pos_q <= POS_W'(7)) begin
				payload_q[pay_idx] <= byte_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q      <= kind;
			sum_ok_q    <= (sum_q == byte_s1);
			axis_x_q    <= {payload_q[1], payload_q[0]};
			axis_y_q    <= {payload_q[3], payload_q[2]};
			axis_z_q    <= {payload_q[5], payload_q[4]};
			group_end_q <= last_pkt;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.packet_kind = kind_q;
	assign res.sum_ok      = sum_ok_q;
	assign res.axis_x      = axis_x_q;
	assign res.axis_y      = axis_y_q;
	assign res.axis_z      = axis_z_q;
	assign res.group_end   = group_end_q;

`ifndef SYNTH
	// hunting only ever happens at the start of a packet and group
	a_hunt_pos: assert property (@(posedge clk) disable iff (!arst_n)
		hunting_q |-> (byte_pos_q == '0 && pkt_pos_q == '0))
		else $error("hunting with nonzero position");

	// byte position never reaches the packet length
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= LAST_POS)
		else $error("byte position out of range");

	// a checksum byte always lands in the result slot
	a_emit_load: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("result lost on checksum byte");

	// a new result only appears from a byte in the input register
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && !hunting_q))
		else $error("result without a source byte");
`endif

endmodule

[dv/tb_imu_packet_frame_parser.sv]
`timescale 1ns / 1ps

module tb_imu_packet_frame_parser;
	import imu_pfp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 150;

	typedef struct packed {
		kind_t              kind;
		logic               sum_ok;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               group_end;
	} packet_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	imu_pfp_byte_if rx_ch ();
	imu_pfp_pkt_if  res_ch ();

	imu_packet_frame_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_ch),
		.res       (res_ch)
	);

	// parser shadow state
	logic [7:0] accel_code, rate_code, angle_code;
	logic       hunting;
	logic [3:0] byte_pos;
	logic [1:0] pkt_pos;
	logic [7:0] run_sum;
	logic [7:0] type_seen;
	logic [7:0] payload [PAYLOAD_BYTES];

	logic [7:0] rx_stream [$];
	packet_t    expected_packets [$];
	packet_t    want_pkt;

	int  gen_pos;
	int  send_gap, recv_gap;
	int  bytes_sent, packets_seen, mismatches, settings_used, cycles;
	bit  calm;
	logic hold_res;

	always #2 clk = ~clk;

	// advance the shadow parser by one accepted byte
	function automatic void frame_byte(logic [7:0] b);
		packet_t p;
		if (hunting) begin
			if (b == HEADER_BYTE) begin
				hunting = 1'b0;
				pkt_pos = '0;
				byte_pos = 4'd1;
				run_sum = b;
			end
			return;
		end
		if (byte_pos < PACKET_BYTES - 1) begin
			if (byte_pos == 4'd1)
				type_seen = b;
			else if (byte_pos >= 4'd2 && byte_pos <= 4'd7)
				payload[byte_pos - 4'd2] = b;
			run_sum = run_sum + b;
			byte_pos = byte_pos + 4'd1;
			return;
		end
		// checksum byte closes the packet; accel beats rate beats angle
		if (type_seen == accel_code)
			p.kind = KIND_ACCEL;
		else if (type_seen == rate_code)
			p.kind = KIND_RATE;
		else if (type_seen == angle_code)
			p.kind = KIND_ANGLE;
		else
			p.kind = KIND_UNKNOWN;
		p.sum_ok = (run_sum == b);
		p.x = {payload[1], payload[0]};
		p.y = {payload[3], payload[2]};
		p.z = {payload[5], payload[4]};
		p.group_end = (pkt_pos == PACKETS_PER_GROUP_DEF - 1);
		expected_packets.push_back(p);
		run_sum = '0;
		byte_pos = '0;
		if (p.group_end) begin
			hunting = 1'b1;
			pkt_pos = '0;
		end else begin
			pkt_pos = pkt_pos + 2'd1;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] rand_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 16'h8000;
		if (r < 20) return 16'h7FFF;
		if (r < 30) return 16'h0000;
		if (r < 40) return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	// body holds bytes 2..9, lowest byte first; sum_flip != 0 corrupts the checksum
	function automatic void queue_packet(logic [7:0] lead, logic [7:0] tbyte,
			logic [63:0] body, logic [7:0] sum_flip);
		logic [7:0] s;
		s = lead + tbyte;
		rx_stream.push_back(lead);
		rx_stream.push_back(tbyte);
		for (int i = 0; i < 8; i++) begin
			s = s + body[8*i +: 8];
			rx_stream.push_back(body[8*i +: 8]);
		end
		rx_stream.push_back(s ^ sum_flip);
	endfunction

	// mostly well-formed groups, with line noise and broken headers mixed in
	function automatic void queue_stream(int n_bytes);
		int         made;
		int         r;
		logic [7:0] lead, tbyte, junk, flip;
		made = 0;
		while (made < n_bytes) begin
			if (gen_pos == 0) begin
				if ($urandom_range(0, 99) < 30) begin
					repeat ($urandom_range(1, 4)) begin
						junk = 8'($urandom_range(0, 255));
						if (junk == HEADER_BYTE && $urandom_range(0, 9) != 0)
							junk = ~junk;
						rx_stream.push_back(junk);
					end
				end
				lead = ($urandom_range(0, 99) < 95) ? HEADER_BYTE : 8'($urandom_range(0, 255));
			end else begin
				lead = $urandom_range(0, 1) ? HEADER_BYTE : 8'($urandom_range(0, 255));
			end
			r = $urandom_range(0, 99);
			if (r < 25)      tbyte = accel_code;
			else if (r < 50) tbyte = rate_code;
			else if (r < 75) tbyte = angle_code;
			else             tbyte = 8'($urandom_range(0, 255));
			flip = ($urandom_range(0, 99) < 85) ? 8'h00 : 8'($urandom_range(1, 255));
			queue_packet(lead, tbyte, {rand_word(), rand_word(), rand_word(), rand_word()}, flip);
			made += PACKET_BYTES;
			gen_pos = (gen_pos + 1) % PACKETS_PER_GROUP_DEF;
		end
	endfunction

	function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
		end
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic write_codes(logic [7:0] a, logic [7:0] r, logic [7:0] g);
		write_reg(CFG_ACCEL_CODE, a);
		write_reg(CFG_RATE_CODE, r);
		write_reg(CFG_ANGLE_CODE, g);
		@(posedge clk);
		cfg_we <= 1'b0;
		accel_code = a;
		rate_code = r;
		angle_code = g;
		settings_used++;
	endtask

	// wait until every byte is taken and every packet has come back
	task automatic wait_drained();
		@(negedge clk);
		while (rx_stream.size() != 0 || rx_ch.valid || expected_packets.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// byte driver
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				frame_byte(rx_ch.rx_byte);
				bytes_sent++;
			end
			if (!rx_ch.valid || rx_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					rx_ch.valid <= 1'b0;
				end else if (rx_stream.size() > 0) begin
					rx_ch.valid <= 1'b1;
					rx_ch.rx_byte <= rx_stream.pop_front();
					send_gap = pick_gap();
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// packet monitor and scoreboard
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				packets_seen++;
				if (expected_packets.size() == 0) begin
					mismatches++;
					$display("%0t: packet with none pending, expected nothing, got kind %0d x %h y %h z %h",
						$time, res_ch.packet_kind, res_ch.axis_x, res_ch.axis_y, res_ch.axis_z);
				end else begin
					want_pkt = expected_packets.pop_front();
					check_field("packet_kind", 16'(want_pkt.kind), 16'(res_ch.packet_kind));
					check_field("sum_ok", 16'(want_pkt.sum_ok), 16'(res_ch.sum_ok));
					check_field("axis_x", want_pkt.x, res_ch.axis_x);
					check_field("axis_y", want_pkt.y, res_ch.axis_y);
					check_field("axis_z", want_pkt.z, res_ch.axis_z);
					check_field("group_end", 16'(want_pkt.group_end), 16'(res_ch.group_end));
				end
				recv_gap = pick_gap();
			end
			if (recv_gap > 0) begin
				recv_gap--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= !hold_res;
			end
		end
	end

	// one long back-pressure stretch while bytes keep coming
	initial begin
		hold_res = 1'b0;
		wait (packets_seen >= 25);
		@(posedge clk);
		hold_res <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_res <= 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// reset, directed bytes, then random phases under several type-code settings
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
		calm = 1'b0;
		accel_code = ACCEL_CODE_RST;
		rate_code = RATE_CODE_RST;
		angle_code = ANGLE_CODE_RST;
		hunting = 1'b1;
		byte_pos = '0;
		pkt_pos = '0;
		run_sum = '0;
		type_seen = '0;
		foreach (payload[i]) payload[i] = '0;
		gen_pos = 0;
		send_gap = 0;
		recv_gap = 0;
		bytes_sent = 0;
		packets_seen = 0;
		mismatches = 0;
		settings_used = 1;
		cycles = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// noise while hunting, one clean packet with extreme axes,
		// then a packet led by a non-header byte with a bad checksum
		@(negedge clk);
		rx_stream.push_back(8'h00);
		rx_stream.push_back(8'hFF);
		queue_packet(HEADER_BYTE, ACCEL_CODE_RST, 64'h00FF_FFFF_7FFF_8000, 8'h00);
		queue_packet(8'hAA, RATE_CODE_RST, 64'h7F80_0001_FFFE_1234, 8'h01);
		gen_pos = 2;
		wait_drained();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_codes(8'h00, 8'h00, 8'h00);
				1: write_codes(8'hFF, 8'h80, 8'h80);
				2: write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				3: write_codes(ACCEL_CODE_RST, RATE_CODE_RST, ANGLE_CODE_RST);
				default: write_codes(8'h01, 8'hFE, HEADER_BYTE);
			endcase
			@(negedge clk);
			calm = (ph == 3);
			queue_stream(200);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		$display("Sent %0d bytes, checked %0d packets under %0d type-code settings.",
			bytes_sent, packets_seen, settings_used);
		$display("Field mismatches: %0d", mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[files.f]
sv/imu_pfp_pkg.sv
sv/imu_pfp_if.sv
sv/imu_packet_frame_parser.sv
dv/tb_imu_packet_frame_parser.sv
